FILE: hdl/skt_pkg.sv
package skt_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SIZE_W  = $clog2(DEPTH + 1);
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MD_INSERT = 2'd0,
        MD_REMOVE = 2'd1,
        MD_READ   = 2'd2,
        MD_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_NEW     = 3'd0,
        ST_RAISED  = 3'd1,
        ST_LOWERED = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_FULL    = 3'd4,
        ST_BADIDX  = 3'd5
    } t_status;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] cnt;
    } t_wr;

    // Flipping the sign bit makes an unsigned compare order two's complement keys.
    function automatic logic [KEY_W-1:0] order_val(input logic [KEY_W-1:0] k, input logic sgn);
        return k ^ {sgn, {(KEY_W - 1){1'b0}}};
    endfunction

endpackage

FILE: hdl/sorted_counted_key_table.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_mode, i_key, i_index
// result    out        o_valid / i_stall  o_status, o_key_out, o_count_out, o_size_out
// config    in         i_cfg_we           i_cfg_data (signed compare)
//
// An item steps through a read and a compare for each entry compared, and through a read
// and a write for each entry moved; the next item is taken only once the sequencer is idle.
// This follows from the single read port of the entry store and its registered read, so
// each compare and each move needs its own read.
// Reset is synchronous and active low; it empties the table and clears the ordering bit.
// A new item is taken only while the sequencer is idle; a result waiting on i_stall
// does not keep the next item out, but that item cannot finish until the result is taken.
module sorted_counted_key_table
    import skt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [INDEX_W-1:0] i_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [KEY_W-1:0]   o_key_out,
    output logic [COUNT_W-1:0] o_count_out,
    output logic [SIZE_W-1:0]  o_size_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CMP  = 6'b000100,
        S_MVRD = 6'b001000,
        S_MVWR = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic               r_signed;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [SIZE_W-1:0]  r_ptr, n_ptr;
    logic [SIZE_W-1:0]  r_pos, n_pos;
    t_mode              r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [KEY_W-1:0]   r_kv, n_kv;
    t_status            r_res_st, n_res_st;
    logic [KEY_W-1:0]   r_res_key, n_res_key;
    logic [COUNT_W-1:0] r_res_cnt, n_res_cnt;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_st;
    logic [KEY_W-1:0]   r_out_key;
    logic [COUNT_W-1:0] r_out_cnt;
    logic [SIZE_W-1:0]  r_out_size;

    t_wr                wr;
    logic [ADDR_W-1:0]  raddr;
    logic [KEY_W-1:0]   rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic [KEY_W-1:0]   rd_kv;
    logic               key_eq;
    logic               key_lt;
    logic               out_free;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] cnt_dec;

    skt_store u_store (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_raddr  (raddr),
        .o_rd_key (rd_key),
        .o_rd_cnt (rd_cnt)
    );

    assign rd_kv    = order_val(rd_key, r_signed);
    assign key_eq   = (rd_kv == r_kv);
    assign key_lt   = (r_kv < rd_kv);
    assign out_free = !r_out_valid || !i_stall;
    assign cnt_inc  = (rd_cnt == COUNT_MAX) ? COUNT_MAX : rd_cnt + COUNT_W'(1);
    assign cnt_dec  = (rd_cnt == '0) ? '0 : rd_cnt - COUNT_W'(1);

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_mode    = r_mode;
        n_key     = r_key;
        n_kv      = r_kv;
        n_res_st  = r_res_st;
        n_res_key = r_res_key;
        n_res_cnt = r_res_cnt;
        wr        = '0;
        raddr     = r_ptr[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode    = t_mode'(i_mode);
                    n_key     = i_key;
                    n_kv      = order_val(i_key, r_signed);
                    n_ptr     = (t_mode'(i_mode) == MD_READ) ? SIZE_W'(i_index) : '0;
                    n_res_key = '0;
                    n_res_cnt = '0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                if (r_mode == MD_READ) begin
                    if (r_ptr < r_size) begin
                        n_state = S_CMP;
                    end else begin
                        n_res_st = ST_BADIDX;
                        n_state  = S_OUT;
                    end
                end else if (r_mode == MD_UNUSED) begin
                    n_res_st = ST_BADIDX;
                    n_state  = S_OUT;
                end else if (r_ptr == r_size) begin
                    if (r_mode == MD_REMOVE) begin
                        n_res_st = ST_ABSENT;
                        n_state  = S_OUT;
                    end else if (r_size == SIZE_W'(DEPTH)) begin
                        n_res_st = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        n_pos   = r_ptr;
                        n_ptr   = r_size;
                        n_state = S_MVRD;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_mode == MD_READ) begin
                    n_res_st  = ST_NEW;
                    n_res_key = rd_key;
                    n_res_cnt = rd_cnt;
                    n_state   = S_OUT;
                end else if (key_eq) begin
                    wr.addr = r_ptr[ADDR_W-1:0];
                    wr.key  = rd_key;
                    if (r_mode == MD_INSERT) begin
                        wr.en     = 1'b1;
                        wr.cnt    = cnt_inc;
                        n_res_st  = ST_RAISED;
                        n_res_cnt = cnt_inc;
                        n_state   = S_OUT;
                    end else begin
                        wr.en     = (cnt_dec != '0);
                        wr.cnt    = cnt_dec;
                        n_res_st  = ST_LOWERED;
                        n_res_cnt = cnt_dec;
                        n_state   = (cnt_dec != '0) ? S_OUT : S_MVRD;
                    end
                end else if (key_lt) begin
                    if (r_mode == MD_REMOVE) begin
                        n_res_st = ST_ABSENT;
                        n_state  = S_OUT;
                    end else if (r_size == SIZE_W'(DEPTH)) begin
                        n_res_st = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        n_pos   = r_ptr;
                        n_ptr   = r_size;
                        n_state = S_MVRD;
                    end
                end else begin
                    n_ptr   = r_ptr + SIZE_W'(1);
                    n_state = S_RD;
                end
            end
            S_MVRD: begin
                if (r_mode == MD_INSERT) begin
                    raddr = ADDR_W'(r_ptr - SIZE_W'(1));
                    if (r_ptr == r_pos) begin
                        wr.en     = 1'b1;
                        wr.addr   = r_pos[ADDR_W-1:0];
                        wr.key    = r_key;
                        wr.cnt    = COUNT_W'(1);
                        n_size    = r_size + SIZE_W'(1);
                        n_res_st  = ST_NEW;
                        n_res_cnt = COUNT_W'(1);
                        n_state   = S_OUT;
                    end else begin
                        n_state = S_MVWR;
                    end
                end else begin
                    raddr = ADDR_W'(r_ptr + SIZE_W'(1));
                    if (r_ptr + SIZE_W'(1) == r_size) begin
                        n_size  = r_size - SIZE_W'(1);
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MVWR;
                    end
                end
            end
            S_MVWR: begin
                wr.en   = 1'b1;
                wr.addr = r_ptr[ADDR_W-1:0];
                wr.key  = rd_key;
                wr.cnt  = rd_cnt;
                n_ptr   = (r_mode == MD_INSERT) ? r_ptr - SIZE_W'(1) : r_ptr + SIZE_W'(1);
                n_state = S_MVRD;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_signed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            if (i_cfg_we) begin
                r_signed <= i_cfg_data;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_pos     <= n_pos;
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_kv      <= n_kv;
        r_res_st  <= n_res_st;
        r_res_key <= n_res_key;
        r_res_cnt <= n_res_cnt;
        if (r_state == S_OUT && out_free) begin
            r_out_st   <= r_res_st;
            r_out_key  <= r_res_key;
            r_out_cnt  <= r_res_cnt;
            r_out_size <= r_size;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_st;
    assign o_key_out   = r_out_key;
    assign o_count_out = r_out_cnt;
    assign o_size_out  = r_out_size;

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SIZE_W'(DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_size_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size == $past(r_size)) || (r_size == $past(r_size) + SIZE_W'(1))
        || (r_size + SIZE_W'(1) == $past(r_size)))
        else $error("Entry count moved by more than one.");

    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MVWR) |-> ($past(r_state) == S_MVRD))
        else $error("Entry move wrote without a preceding read.");

    a_move_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MVWR) |-> (r_ptr <= r_size))
        else $error("Entry move addresses beyond the held entries.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_RD))
        else $error("Accepted item did not start the sequencer.");

endmodule

FILE: hdl/skt_store.sv
module skt_store
    import skt_pkg::*;
(
    input  logic               i_clk,
    input  t_wr                i_wr,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [KEY_W-1:0]   o_rd_key,
    output logic [COUNT_W-1:0] o_rd_cnt
);

    logic [KEY_W-1:0]   r_mem_key [DEPTH];
    logic [COUNT_W-1:0] r_mem_cnt [DEPTH];
    logic [KEY_W-1:0]   r_rd_key;
    logic [COUNT_W-1:0] r_rd_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_key[i_wr.addr] <= i_wr.key;
            r_mem_cnt[i_wr.addr] <= i_wr.cnt;
        end
        r_rd_key <= r_mem_key[i_raddr];
        r_rd_cnt <= r_mem_cnt[i_raddr];
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_cnt = r_rd_cnt;

endmodule

FILE: tb/sv/sorted_counted_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_counted_key_table_tb;
    import skt_pkg::*;

    localparam int RUN_LIMIT = 16_000_000;
    localparam int TAIL_CYCLES = 4 * DEPTH + 8;
    localparam int SAT_INSERTS = 40;

    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
    } t_table_op;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [SIZE_W-1:0]  size;
    } t_table_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_data = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [MODE_W-1:0]  i_mode = '0;
    logic [KEY_W-1:0]   i_key = '0;
    logic [INDEX_W-1:0] i_index = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [KEY_W-1:0]   o_key_out;
    logic [COUNT_W-1:0] o_count_out;
    logic [SIZE_W-1:0]  o_size_out;

    sorted_counted_key_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_index     (i_index),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_key_out   (o_key_out),
        .o_count_out (o_count_out),
        .o_size_out  (o_size_out)
    );

    always #2 i_clk = ~i_clk;

    logic [KEY_W-1:0]   table_keys [DEPTH];
    logic [COUNT_W-1:0] table_counts [DEPTH];
    int unsigned        table_size = 0;
    logic               order_signed = 1'b0;

    t_table_op     pending_ops[$];
    t_table_result results_due[$];
    int            ops_in_flight = 0;
    int            errors = 0;
    int            cyc = 0;
    logic          item_taken = 1'b0;
    logic          quiet = 1'b0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    t_table_op     nxt_op;
    t_table_result got;
    t_table_result want;

    function automatic logic [KEY_W-1:0] key_rank(input logic [KEY_W-1:0] k);
        return {k[KEY_W-1] ^ order_signed, k[KEY_W-2:0]};
    endfunction

    task automatic apply_table_op(input t_table_op op);
        int unsigned   pos;
        int unsigned   p;
        logic          hit;
        logic          stop;
        t_table_result res;
        pos = 0;
        hit = 1'b0;
        stop = 1'b0;
        res.status = ST_BADIDX;
        res.key = '0;
        res.count = '0;
        if (op.mode == MD_INSERT || op.mode == MD_REMOVE) begin
            while (!stop && pos < table_size) begin
                if (key_rank(table_keys[pos]) == key_rank(op.key)) begin
                    hit = 1'b1;
                    stop = 1'b1;
                end else if (key_rank(op.key) < key_rank(table_keys[pos])) begin
                    stop = 1'b1;
                end else begin
                    pos++;
                end
            end
        end
        case (op.mode)
            MD_INSERT: begin
                if (hit) begin
                    if (table_counts[pos] != COUNT_MAX)
                        table_counts[pos] = table_counts[pos] + 1'b1;
                    res.status = ST_RAISED;
                    res.count = table_counts[pos];
                end else if (table_size >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (p = table_size; p > pos; p--) begin
                        table_keys[p] = table_keys[p-1];
                        table_counts[p] = table_counts[p-1];
                    end
                    table_keys[pos] = op.key;
                    table_counts[pos] = COUNT_W'(1);
                    table_size++;
                    res.status = ST_NEW;
                    res.count = COUNT_W'(1);
                end
            end
            MD_REMOVE: begin
                if (hit) begin
                    table_counts[pos] = table_counts[pos] - 1'b1;
                    res.count = table_counts[pos];
                    if (table_counts[pos] == 0) begin
                        for (p = pos; p + 1 < table_size; p++) begin
                            table_keys[p] = table_keys[p+1];
                            table_counts[p] = table_counts[p+1];
                        end
                        table_size--;
                    end
                    res.status = ST_LOWERED;
                end else begin
                    res.status = ST_ABSENT;
                end
            end
            MD_READ: begin
                if (op.index < table_size) begin
                    res.status = ST_NEW;
                    res.key = table_keys[op.index];
                    res.count = table_counts[op.index];
                end
            end
            default: begin
            end
        endcase
        res.size = SIZE_W'(table_size);
        results_due.push_back(res);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // Acceptance, prediction and result checking all happen on the rising edge.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        item_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_we)
                order_signed = i_cfg_data;
            if (i_valid && !o_stall) begin
                apply_table_op('{mode: t_mode'(i_mode), key: i_key, index: i_index});
                ops_in_flight--;
            end
            if (o_valid && !i_stall) begin
                got = '{status: t_status'(o_status), key: o_key_out, count: o_count_out,
                        size: o_size_out};
                if (results_due.size() == 0) begin
                    $display("%0t ns: extra result, status %0d key %h count %0d size %0d",
                             $time, o_status, o_key_out, o_count_out, o_size_out);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("key_out", 32'(want.key), 32'(got.key));
                    check_field("count_out", 32'(want.count), 32'(got.count));
                    check_field("size_out", 32'(want.size), 32'(got.size));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cyc >= RUN_LIMIT) begin
            $display("sorted_counted_key_table verification failed");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            if (gap_left > 0 && !quiet) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                nxt_op = pending_ops.pop_front();
                i_valid <= 1'b1;
                i_mode <= nxt_op.mode;
                i_key <= nxt_op.key;
                i_index <= nxt_op.index;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls come in short runs, with stall-free windows in between.
    always @(negedge i_clk) begin
        if (stall_left == 0 && i_rst_n && !quiet && cyc[8:7] != 2'd0
            && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 6);
        i_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    task automatic push_op(input t_mode m, input logic [KEY_W-1:0] k,
                           input logic [INDEX_W-1:0] ix);
        pending_ops.push_back('{mode: m, key: k, index: ix});
        ops_in_flight++;
    endtask

    task automatic settle();
        while (ops_in_flight != 0 || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_ordering(input logic sgn);
        settle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= sgn;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int ins_pct);
        logic [KEY_W-1:0] pool [24];
        int               r;
        int               rem_end;
        int               i;
        logic [KEY_W-1:0] k;
        t_mode            m;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFF;
        for (i = 4; i < 24; i++)
            pool[i] = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 63)) - 32);
        rem_end = ins_pct + (95 - ins_pct) * 3 / 5;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                m = MD_INSERT;
            else if (r < rem_end)
                m = MD_REMOVE;
            else if (r < 95)
                m = MD_READ;
            else
                m = MD_UNUSED;
            k = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 23)] : $urandom();
            push_op(m, k, INDEX_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 99) == 0)
                settle();
        end
    endtask

    initial begin
        int               i;
        logic [KEY_W-1:0] sat_key;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_ordering(1'b0);
        push_op(MD_READ, 32'h0, 4'd0);
        push_op(MD_REMOVE, 32'h5, 4'd0);
        push_op(MD_UNUSED, 32'hFFFF_FFFF, 4'hF);
        push_op(MD_INSERT, 32'h0000_0000, 4'd0);
        push_op(MD_INSERT, 32'hFFFF_FFFF, 4'hF);
        push_op(MD_INSERT, 32'h8000_0000, 4'd0);
        push_op(MD_INSERT, 32'h7FFF_FFFF, 4'd0);
        push_op(MD_INSERT, 32'hFFFF_FFFF, 4'd0);
        push_op(MD_REMOVE, 32'hFFFF_FFFF, 4'd0);
        push_op(MD_REMOVE, 32'hFFFF_FFFF, 4'd0);
        for (i = 1; i <= 13; i++)
            push_op(MD_INSERT, 32'h1111_1111 * i, 4'(i));
        push_op(MD_INSERT, 32'h1234_5678, 4'd0);
        push_op(MD_READ, 32'h0, 4'hF);
        push_op(MD_READ, 32'hFFFF_FFFF, 4'd0);

        set_ordering(1'b1);
        random_phase(500, 55);
        set_ordering(1'b0);
        random_phase(450, 35);
        set_ordering(1'b1);
        random_phase(450, 60);
        set_ordering(1'b0);
        random_phase(450, 40);

        // Repeat one key many times, with no idling on either side.
        settle();
        quiet = 1'b1;
        sat_key = (table_size != 0) ? table_keys[0] : 32'h0;
        for (i = 0; i < SAT_INSERTS; i++)
            push_op(MD_INSERT, sat_key, 4'd0);
        push_op(MD_REMOVE, sat_key, 4'd0);
        push_op(MD_INSERT, sat_key, 4'd0);
        push_op(MD_INSERT, sat_key, 4'd0);
        push_op(MD_READ, 32'h0, 4'd0);
        settle();
        quiet = 1'b0;

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && results_due.size() == 0)
            $display("sorted_counted_key_table verification clean");
        else
            $display("sorted_counted_key_table verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/skt_pkg.sv
hdl/skt_store.sv
hdl/sorted_counted_key_table.sv
tb/sv/sorted_counted_key_table_tb.sv
